// File: src/c2sa_pkg.sv
// Shared constants, flag type and arctangent table for the Cartesian to
// spherical angle converter. No dependencies.
package c2sa_pkg;

  localparam int COORD_BITS_DEF     = 24;
  localparam int ANGLE_BITS_DEF     = 16;
  localparam int ROTATION_STEPS_DEF = 16;

  // Fraction bits added below the coordinate magnitudes
  localparam int GUARD_BITS = 24;
  // Entries in the arctangent table
  localparam int TABLE_LEN  = 28;
  // Angles accumulate in 2^-32 turn
  localparam int TURN_BITS  = 32;
  // Signed angle accumulator width (sum of the table stays below 2^31)
  localparam int ACC_BITS   = 34;

  // K scaled by 2^30, applied to |z| so that it meets K*rxy at equal gain
  localparam int             GAIN_BITS = 31;
  localparam logic [30:0]    GAIN_Q30  = 31'd1768195363;
  localparam int             MUL_SHIFT = 30 - GUARD_BITS;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

  typedef struct packed {
    logic zero;    // all three components zero
    logic xn;      // x negative
    logic yn;      // y negative
    logic zn;      // z negative
    logic y_zero;  // y exactly zero
  } c2sa_flags_t;

  localparam int FLAGS_BITS = $bits(c2sa_flags_t);

  // atan(2^-idx) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int idx);
    case (idx)
      0:       return 32'h20000000;
      1:       return 32'h12E4051E;
      2:       return 32'h09FB385B;
      3:       return 32'h051111D4;
      4:       return 32'h028B0D43;
      5:       return 32'h0145D7E1;
      6:       return 32'h00A2F61E;
      7:       return 32'h00517C55;
      8:       return 32'h0028BE53;
      9:       return 32'h00145F2F;
      10:      return 32'h000A2F98;
      11:      return 32'h000517CC;
      12:      return 32'h00028BE6;
      13:      return 32'h000145F3;
      14:      return 32'h0000A2FA;
      15:      return 32'h0000517D;
      16:      return 32'h000028BE;
      17:      return 32'h0000145F;
      18:      return 32'h00000A30;
      19:      return 32'h00000518;
      20:      return 32'h0000028C;
      21:      return 32'h00000146;
      22:      return 32'h000000A3;
      23:      return 32'h00000051;
      24:      return 32'h00000029;
      25:      return 32'h00000014;
      26:      return 32'h0000000A;
      27:      return 32'h00000005;
      default: return 32'h00000000;
    endcase
  endfunction

endpackage

// File: src/cartesian_to_spherical_angles.sv
// Top level of the Cartesian to spherical angle converter: input staging,
// gain multiply, two CORDIC chains, angle assembly and output skid buffer.
// Depends on c2sa_pkg and c2sa_vector.

// Converts one signed 3-D vector (x, y, z) per transfer into its polar angle
// theta (from +z, 0 to pi) and its azimuth phi (0 to 2pi), both coded as
// fractions of a full turn with 2^ANGLE_BITS codes per turn. Phi is 0 when y
// is exactly zero, whatever x is. An all-zero vector gives zero angles and
// sets the zero_vector flag in tuser. The block is fully pipelined: it takes
// one transfer every cycle while its skid register is free and delivers
// one result per transfer, in order. The path from input transfer to the
// result on the master side holds one register stage for the magnitudes, one
// for the z gain multiply, one stage per CORDIC iteration in each of the two
// vectoring chains (first the x-y plane, then rxy against z), one stage for
// the angle assembly and rounding, and the output register. A two-entry skid
// buffer at the output keeps the pipeline moving for one more result while
// the downstream side stalls, then holds the whole pipeline without loss.
// There are no configuration registers and no state beyond the pipeline.
module cartesian_to_spherical_angles #(
  parameter int COORD_BITS     = c2sa_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS     = c2sa_pkg::ANGLE_BITS_DEF,
  parameter int ROTATION_STEPS = c2sa_pkg::ROTATION_STEPS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0 up: x_coord, y_coord, z_coord (COORD_BITS each, signed)
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // Fields from bit 0 up: theta_angle, phi_angle (ANGLE_BITS each)
  output logic [((2*ANGLE_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // Fields from bit 0 up: zero_vector
  output logic                                   m_axis_tuser
);
  import c2sa_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int AB     = ANGLE_BITS;
  localparam int OUT_W  = ((2*AB+7)/8)*8;
  // Datapath width: magnitude plus guard bits, CORDIC growth and sign
  localparam int W      = CB + GUARD_BITS + 4;
  localparam int PROD_W = CB + GAIN_BITS;
  localparam int C_W    = PROD_W - MUL_SHIFT;
  localparam int NSTEP  = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;
  localparam int RND_SH = TURN_BITS - AB;
  localparam int SIDE1  = W + FLAGS_BITS;
  localparam int SIDE2  = TURN_BITS + FLAGS_BITS;

  // Whole pipeline advances while the skid register is free
  logic pipe_adv;

  //--------------------------------------------------------------------------
  // Stage A: magnitudes and sign flags
  //--------------------------------------------------------------------------
  logic [CB-1:0] raw_x, raw_y, raw_z;
  logic [CB-1:0] mag_x_next, mag_y_next, mag_z_next;
  c2sa_flags_t   flags_next;

  assign raw_x = s_axis_tdata[CB-1:0];
  assign raw_y = s_axis_tdata[2*CB-1:CB];
  assign raw_z = s_axis_tdata[3*CB-1:2*CB];

  // Two's complement negate; the most negative code keeps its magnitude
  assign mag_x_next = raw_x[CB-1] ? (~raw_x + CB'(1)) : raw_x;
  assign mag_y_next = raw_y[CB-1] ? (~raw_y + CB'(1)) : raw_y;
  assign mag_z_next = raw_z[CB-1] ? (~raw_z + CB'(1)) : raw_z;

  always_comb begin
    flags_next.zero   = (raw_x == '0) && (raw_y == '0) && (raw_z == '0);
    flags_next.xn     = raw_x[CB-1];
    flags_next.yn     = raw_y[CB-1];
    flags_next.zn     = raw_z[CB-1];
    flags_next.y_zero = (raw_y == '0);
  end

  logic          mag_valid;
  logic [CB-1:0] mag_x, mag_y, mag_z;
  c2sa_flags_t   mag_flags;

  assign s_axis_tready = pipe_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (pipe_adv) begin
      mag_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      mag_x     <= mag_x_next;
      mag_y     <= mag_y_next;
      mag_z     <= mag_z_next;
      mag_flags <= flags_next;
    end
  end

  //--------------------------------------------------------------------------
  // Stage B: scale x, y by the guard bits; multiply |z| by K
  //--------------------------------------------------------------------------
  logic [PROD_W-1:0] prod;
  assign prod = PROD_W'(mag_z) * PROD_W'(GAIN_Q30);

  logic               pre_valid;
  logic signed [W-1:0] pre_x, pre_y, pre_c;
  c2sa_flags_t        pre_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else if (pipe_adv) begin
      pre_valid <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      pre_x     <= $signed({{(W-CB-GUARD_BITS){1'b0}}, mag_x, {GUARD_BITS{1'b0}}});
      pre_y     <= $signed({{(W-CB-GUARD_BITS){1'b0}}, mag_y, {GUARD_BITS{1'b0}}});
      pre_c     <= $signed({{(W-C_W){1'b0}}, prod[PROD_W-1:MUL_SHIFT]});
      pre_flags <= mag_flags;
    end
  end

  //--------------------------------------------------------------------------
  // Chain 1: vector (|x|, |y|) to get alpha and K*rxy; carry K*|z| along
  //--------------------------------------------------------------------------
  logic                 v1_valid;
  logic signed [W-1:0]  v1_x;
  logic [TURN_BITS-1:0] v1_ang;
  logic [SIDE1-1:0]     v1_side;

  c2sa_vector #(
    .W      (W),
    .STEPS  (NSTEP),
    .SIDE_W (SIDE1)
  ) u_vec_xy (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_adv),
    .in_valid  (pre_valid),
    .in_x      (pre_x),
    .in_y      (pre_y),
    .in_side   ({pre_c, pre_flags}),
    .out_valid (v1_valid),
    .out_x     (v1_x),
    .out_ang   (v1_ang),
    .out_side  (v1_side)
  );

  //--------------------------------------------------------------------------
  // Chain 2: vector (K*|z|, K*rxy) to get beta; carry alpha along
  //--------------------------------------------------------------------------
  logic signed [W-1:0]  v1_c;
  c2sa_flags_t          v1_flags;
  assign v1_c     = $signed(v1_side[SIDE1-1:FLAGS_BITS]);
  assign v1_flags = v1_side[FLAGS_BITS-1:0];

  logic                 v2_valid;
  logic signed [W-1:0]  v2_x;
  logic [TURN_BITS-1:0] v2_ang;
  logic [SIDE2-1:0]     v2_side;

  c2sa_vector #(
    .W      (W),
    .STEPS  (NSTEP),
    .SIDE_W (SIDE2)
  ) u_vec_rz (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_adv),
    .in_valid  (v1_valid),
    .in_x      (v1_c),
    .in_y      (v1_x),
    .in_side   ({v1_ang, v1_flags}),
    .out_valid (v2_valid),
    .out_x     (v2_x),
    .out_ang   (v2_ang),
    .out_side  (v2_side)
  );

  //--------------------------------------------------------------------------
  // Final stage: place angles in their quadrants, round to ANGLE_BITS
  //--------------------------------------------------------------------------
  logic [TURN_BITS-1:0] alpha, beta, base, phi_full, theta_full;
  c2sa_flags_t          fl;
  logic [AB-1:0]        theta_next, phi_next;

  assign alpha = v2_side[SIDE2-1:FLAGS_BITS];
  assign fl    = v2_side[FLAGS_BITS-1:0];
  assign beta  = v2_ang;

  // Round half up, drop the whole-turn bit so a full turn wraps to 0
  function automatic logic [AB-1:0] round_angle(input logic [TURN_BITS-1:0] t);
    logic [TURN_BITS:0] sum;
    sum = {1'b0, t} + ({{TURN_BITS{1'b0}}, 1'b1} << (RND_SH - 1));
    return sum[TURN_BITS-1:RND_SH];
  endfunction

  always_comb begin
    base       = fl.xn ? (HALF_TURN - alpha) : alpha;
    phi_full   = fl.y_zero ? '0 : (fl.yn ? ('0 - base) : base);
    theta_full = fl.zn ? (HALF_TURN - beta) : beta;
    if (fl.zero) begin
      theta_next = '0;
      phi_next   = '0;
    end else begin
      theta_next = round_angle(theta_full);
      phi_next   = round_angle(phi_full);
    end
  end

  logic          fin_valid;
  logic [AB-1:0] fin_theta, fin_phi;
  logic          fin_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (pipe_adv) begin
      fin_valid <= v2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      fin_theta <= theta_next;
      fin_phi   <= phi_next;
      fin_zero  <= fl.zero;
    end
  end

  //--------------------------------------------------------------------------
  // Output register with skid: take a result while the last one still waits
  //--------------------------------------------------------------------------
  logic          out_valid, skid_valid;
  logic [AB-1:0] out_theta, out_phi, skid_theta, skid_phi;
  logic          out_zero, skid_zero;
  logic          fin_xfer, out_free;

  assign pipe_adv = !skid_valid;
  assign fin_xfer = fin_valid && pipe_adv;
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (fin_xfer) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_valid && m_axis_tready) begin
      // Refill from the skid register, or drain
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_xfer) begin
      if (out_free) begin
        out_theta <= fin_theta;
        out_phi   <= fin_phi;
        out_zero  <= fin_zero;
      end else begin
        skid_theta <= fin_theta;
        skid_phi   <= fin_phi;
        skid_zero  <= fin_zero;
      end
    end else if (out_valid && m_axis_tready && skid_valid) begin
      out_theta <= skid_theta;
      out_phi   <= skid_phi;
      out_zero  <= skid_zero;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'({out_phi, out_theta});
  assign m_axis_tuser  = out_zero;

endmodule

// File: src/c2sa_vector.sv
// Pipelined CORDIC vectoring chain, one register stage per iteration.
// Depends on c2sa_pkg (arctangent table, accumulator width, quarter turn).
module c2sa_vector #(
  parameter int W      = 52,
  parameter int STEPS  = 16,
  parameter int SIDE_W = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [W-1:0]                 in_x,
  input  logic signed [W-1:0]                 in_y,
  input  logic [SIDE_W-1:0]                   in_side,
  output logic                                out_valid,
  output logic signed [W-1:0]                 out_x,
  output logic [c2sa_pkg::TURN_BITS-1:0]      out_ang,
  output logic [SIDE_W-1:0]                   out_side
);
  import c2sa_pkg::*;

  logic                       vld  [STEPS];
  logic signed [W-1:0]        xs   [STEPS];
  logic signed [W-1:0]        ys   [STEPS];
  logic signed [ACC_BITS-1:0] angs [STEPS];
  logic [SIDE_W-1:0]          sides[STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic                       pv;
    logic signed [W-1:0]        px, py, xsh, ysh, nx, ny;
    logic signed [ACC_BITS-1:0] pa, na, rot;
    logic [SIDE_W-1:0]          ps;

    if (i == 0) begin : g_first
      assign pv = in_valid;
      assign px = in_x;
      assign py = in_y;
      assign pa = '0;
      assign ps = in_side;
    end else begin : g_next
      assign pv = vld[i-1];
      assign px = xs[i-1];
      assign py = ys[i-1];
      assign pa = angs[i-1];
      assign ps = sides[i-1];
    end

    assign xsh = px >>> i;
    assign ysh = py >>> i;
    assign rot = $signed({2'b00, atan_turn(i)});

    // Rotate toward the x axis by the sign of y
    always_comb begin
      if (!py[W-1]) begin
        nx = px + ysh;
        ny = py - xsh;
        na = pa + rot;
      end else begin
        nx = px - ysh;
        ny = py + xsh;
        na = pa - rot;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[i]    <= nx;
        ys[i]    <= ny;
        angs[i]  <= na;
        sides[i] <= ps;
      end
    end
  end

  logic signed [ACC_BITS-1:0] acc_last;
  assign acc_last = angs[STEPS-1];

  // Clamp the angle to [0, quarter turn]
  always_comb begin
    if (acc_last[ACC_BITS-1]) begin
      out_ang = '0;
    end else if (acc_last > $signed({2'b00, QUARTER_TURN})) begin
      out_ang = QUARTER_TURN;
    end else begin
      out_ang = acc_last[TURN_BITS-1:0];
    end
  end

  assign out_valid = vld[STEPS-1];
  assign out_x     = xs[STEPS-1];
  assign out_side  = sides[STEPS-1];

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for cartesian_to_spherical_angles: streams 3-D vectors in bursts,
// stalls the result side, predicts theta/phi with its own CORDIC model and compares.
// Depends on c2sa_pkg (parameter defaults) and the converter sources.
module tb_top;

  localparam int CB    = c2sa_pkg::COORD_BITS_DEF;
  localparam int AB    = c2sa_pkg::ANGLE_BITS_DEF;
  localparam int STEPS = c2sa_pkg::ROTATION_STEPS_DEF;
  localparam int IN_W  = ((3*CB+7)/8)*8;
  localparam int OUT_W = ((2*AB+7)/8)*8;

  // Input transfer to result, summed from the converter's register stages
  localparam int LATENCY      = 2*STEPS + 4;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 480;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_REPORTS  = 10;

  // Fixed-point setup of the angle datapath
  localparam int              FRAC_BITS  = 24;
  localparam longint unsigned Z_GAIN     = 64'd1768195363;
  localparam longint          QUARTER_T  = 64'sh4000_0000;
  localparam longint unsigned HALF_T     = 64'h8000_0000;
  localparam longint unsigned FULL_T     = 64'h1_0000_0000;

  localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

  typedef struct packed {
    logic [AB-1:0] theta;
    logic [AB-1:0] phi;
    logic          zero;
  } angle_result_t;

  typedef struct packed {
    logic signed [63:0] mag;
    logic signed [63:0] ang;
  } rotation_t;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic                 known;
    angle_result_t        want;
  } vec_row_t;

  typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_DUTY, READY_SPARSE} ready_shape_e;

  // atan(2^-i) in 2^-32 turn
  logic [31:0] arctan_lut [0:27] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;

  angle_result_t angles_due [$];
  angle_result_t got_angles;
  angle_result_t due_angles;
  vec_row_t      directed_rows [$];

  int  mismatch_count  = 0;
  int  results_checked = 0;
  int  vectors_sent    = 0;
  int  zero_vectors    = 0;
  int  y_zero_vectors  = 0;
  int  long_holds      = 0;
  int  cycle_count     = 0;
  bit  backpressure_req = 1'b0;

  cartesian_to_spherical_angles u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Vectoring CORDIC from the first quadrant. Shifts of signed values floor,
  // the accumulated angle is clamped to one quarter turn.
  function automatic rotation_t rotate_to_axis(input longint xr, input longint yr);
    rotation_t res;
    longint    ang;
    longint    nx;
    int        i;
    ang = 0;
    for (i = 0; i < STEPS && i < 28; i++) begin
      if (yr >= 0) begin
        nx  = xr + (yr >>> i);
        yr  = yr - (xr >>> i);
        ang = ang + $signed({32'd0, arctan_lut[i]});
      end else begin
        nx  = xr - (yr >>> i);
        yr  = yr + (xr >>> i);
        ang = ang - $signed({32'd0, arctan_lut[i]});
      end
      xr = nx;
    end
    if (ang < 0) ang = 0;
    if (ang > QUARTER_T) ang = QUARTER_T;
    res.mag = xr;
    res.ang = ang;
    return res;
  endfunction

  // Round a 2^-32 turn angle half up to AB bits, wrapping a full turn to 0
  function automatic logic [AB-1:0] to_angle_code(input longint unsigned turns);
    longint unsigned t;
    t = (turns + (64'd1 << (31 - AB))) >> (32 - AB);
    return t[AB-1:0];
  endfunction

  function automatic angle_result_t spherical_angles(input logic signed [CB-1:0] xc,
                                                     input logic signed [CB-1:0] yc,
                                                     input logic signed [CB-1:0] zc);
    angle_result_t   r;
    logic [CB-1:0]   mx, my, mz;
    rotation_t       xy, rz;
    longint unsigned base, phi_t, theta_t, z_scaled;
    // The most negative value keeps its magnitude as an unsigned number
    mx = xc[CB-1] ? -xc : xc;
    my = yc[CB-1] ? -yc : yc;
    mz = zc[CB-1] ? -zc : zc;
    r = '0;
    if (mx == 0 && my == 0 && mz == 0) begin
      r.zero = 1'b1;
      return r;
    end
    xy = rotate_to_axis(longint'(mx) << FRAC_BITS, longint'(my) << FRAC_BITS);
    if (my == 0) begin
      phi_t = 0;
    end else begin
      base  = xc[CB-1] ? HALF_T - longint'(xy.ang) : longint'(xy.ang);
      phi_t = yc[CB-1] ? (FULL_T - base) & (FULL_T - 1) : base;
    end
    // Bring |z| to the same CORDIC gain as rxy before the second rotation
    z_scaled = (longint'(mz) * Z_GAIN) >> (30 - FRAC_BITS);
    rz = rotate_to_axis(longint'(z_scaled), xy.mag);
    theta_t = zc[CB-1] ? HALF_T - longint'(rz.ang) : longint'(rz.ang);
    r.theta = to_angle_code(theta_t);
    r.phi   = to_angle_code(phi_t);
    return r;
  endfunction

  function automatic void add_row(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
                                  input logic signed [CB-1:0] z, input logic known,
                                  input logic [AB-1:0] theta, input logic [AB-1:0] phi,
                                  input logic zero);
    vec_row_t row;
    row.x          = x;
    row.y          = y;
    row.z          = z;
    row.known      = known;
    row.want.theta = theta;
    row.want.phi   = phi;
    row.want.zero  = zero;
    directed_rows.push_back(row);
  endfunction

  function automatic logic signed [CB-1:0] random_coord();
    logic signed [CB-1:0] v;
    v = CB'($urandom);
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = C_MAX;
      2:       v = C_MIN;
      3:       v = v >>> (CB - 5);
      4, 5:    v = v >>> (CB - 13);
      default: ;
    endcase
    return v;
  endfunction

  function automatic void flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Offer one vector and hold it until the converter takes it
  task automatic send_vector(input logic signed [CB-1:0] vx, input logic signed [CB-1:0] vy,
                             input logic signed [CB-1:0] vz, input logic known,
                             input angle_result_t want);
    logic [IN_W-1:0] word;
    word = '0;
    word[CB-1:0]      = vx;
    word[2*CB-1:CB]   = vy;
    word[3*CB-1:2*CB] = vz;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
    angles_due.push_back(known ? want : spherical_angles(vx, vy, vz));
    vectors_sent++;
    if (vx == 0 && vy == 0 && vz == 0) zero_vectors++;
    if (vy == 0) y_zero_vectors++;
  endtask

  // Drop valid and put junk on the data bus while idle
  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_W'({$urandom, $urandom, $urandom});
    end
  endtask

  task automatic wait_all_results();
    while (angles_due.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed table, then bursty random vectors
  initial begin : stimulus
    vec_row_t             row;
    logic signed [CB-1:0] rx, ry, rz;
    int                   burst;
    int                   sent;
    int                   shape;
    bit                   hold_done;
    bit                   drain_done;

    hold_done  = 1'b0;
    drain_done = 1'b0;

    //       x       y       z       known theta phi zero
    add_row('0,     '0,     '0,     1'b1, '0,   '0, 1'b1);  // zero vector
    add_row('0,     '0,     C_MAX,  1'b0, '0,   '0, 1'b0);  // straight up
    add_row('0,     '0,     C_MIN,  1'b0, '0,   '0, 1'b0);  // straight down, full-scale
    add_row('0,     '0,     -1,     1'b0, '0,   '0, 1'b0);
    add_row(C_MAX,  '0,     '0,     1'b0, '0,   '0, 1'b0);  // y zero, x positive
    add_row(C_MIN,  '0,     '0,     1'b0, '0,   '0, 1'b0);  // y zero, x negative
    add_row(-1,     '0,     '0,     1'b0, '0,   '0, 1'b0);
    add_row(1,      '0,     '0,     1'b0, '0,   '0, 1'b0);
    add_row(5,      '0,     -5,     1'b0, '0,   '0, 1'b0);
    add_row('0,     C_MAX,  '0,     1'b0, '0,   '0, 1'b0);
    add_row('0,     C_MIN,  '0,     1'b0, '0,   '0, 1'b0);
    add_row('0,     1,      '0,     1'b0, '0,   '0, 1'b0);
    add_row('0,     -1,     '0,     1'b0, '0,   '0, 1'b0);
    add_row(C_MAX,  C_MAX,  C_MAX,  1'b0, '0,   '0, 1'b0);
    add_row(C_MIN,  C_MIN,  C_MIN,  1'b0, '0,   '0, 1'b0);
    add_row(C_MAX,  C_MIN,  C_MAX,  1'b0, '0,   '0, 1'b0);
    add_row(-1,     -1,     -1,     1'b0, '0,   '0, 1'b0);
    add_row(1,      1,      1,      1'b0, '0,   '0, 1'b0);
    add_row(1,      -1,     '0,     1'b0, '0,   '0, 1'b0);
    add_row(-1,     1,      '0,     1'b0, '0,   '0, 1'b0);
    add_row(C_MIN,  1,      '0,     1'b0, '0,   '0, 1'b0);  // azimuth just under half turn
    add_row(C_MAX,  -1,     '0,     1'b0, '0,   '0, 1'b0);  // azimuth rounds up to a full turn
    add_row(C_MIN,  -1,     C_MAX,  1'b0, '0,   '0, 1'b0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 4));
      send_vector(row.x, row.y, row.z, row.known, row.want);
    end
    idle_for(1);
    wait_all_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      // Long output hold while input keeps coming: the pipeline must fill and push back
      if (!hold_done && sent >= 150) begin
        backpressure_req = 1'b1;
        hold_done = 1'b1;
        burst = 120;
      end
      // Let the converter empty out completely once mid-run
      if (!drain_done && sent >= 350) begin
        drain_done = 1'b1;
        idle_for(1);
        wait_all_results();
      end
      repeat (burst) begin
        if (sent < RANDOM_ITEMS) begin
          rx = random_coord();
          ry = random_coord();
          rz = random_coord();
          shape = $urandom_range(0, 39);
          if (shape == 0) begin
            rx = '0;
            ry = '0;
            rz = '0;
          end else if (shape < 4) begin
            ry = '0;
          end else if (shape < 6) begin
            rx = '0;
            ry = '0;
          end
          send_vector(rx, ry, rz, 1'b0, '0);
          sent++;
        end
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
    end

    idle_for(1);
    wait_all_results();
    repeat (2*LATENCY) @(posedge clk);

    $display("Sent %0d vectors (%0d all-zero, %0d with y = 0), checked %0d results.",
             vectors_sent, zero_vectors, y_zero_vectors, results_checked);
    $display("Output held off %0d time(s) for %0d cycles; %0d mismatch(es).",
             long_holds, HOLD_CYCLES, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: a changing ready pattern, plus one long hold on request
  initial begin : result_side
    ready_shape_e shape;
    int           left;
    logic         ready;
    shape = READY_ALWAYS;
    left  = 0;
    forever begin
      @(negedge clk);
      if (backpressure_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        backpressure_req = 1'b0;
        long_holds++;
      end else begin
        if (left == 0) begin
          shape = ready_shape_e'($urandom_range(0, 3));
          left  = $urandom_range(8, 60);
        end
        left--;
        case (shape)
          READY_ALWAYS: ready = 1'b1;
          READY_COIN:   ready = $urandom_range(0, 1);
          READY_DUTY:   ready = (left % 4) != 0;
          default:      ready = ($urandom_range(0, 7) == 0);
        endcase
        m_axis_tready <= ready;
      end
    end
  end

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_angles.theta = m_axis_tdata[AB-1:0];
      got_angles.phi   = m_axis_tdata[2*AB-1:AB];
      got_angles.zero  = m_axis_tuser;
      if (angles_due.size() == 0) begin
        flag_error($sformatf("Unexpected result: theta=%0d phi=%0d zero=%0b",
                             got_angles.theta, got_angles.phi, got_angles.zero));
      end else begin
        due_angles = angles_due.pop_front();
        results_checked++;
        if (got_angles.theta !== due_angles.theta || got_angles.phi !== due_angles.phi ||
            got_angles.zero !== due_angles.zero) begin
          flag_error($sformatf(
            "Result %0d: expected theta=%0d phi=%0d zero=%0b, got theta=%0d phi=%0d zero=%0b",
            results_checked, due_angles.theta, due_angles.phi, due_angles.zero,
            got_angles.theta, got_angles.phi, got_angles.zero));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, angles_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
